// ===== sv/ssc_pkg.sv =====
// shared types and constants for the script run segment candidate counter
package ssc_pkg;

    localparam int CLS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int LIM_W  = 8;
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 2;

    localparam logic [CLS_W-1:0] C_HIRA  = 5'd8;
    localparam logic [CLS_W-1:0] C_KATA  = 5'd9;
    localparam logic [CLS_W-1:0] C_HANJI = 5'd10;
    localparam logic [CLS_W-1:0] C_HK    = 5'd11;
    localparam logic [CLS_W-1:0] C_HH    = 5'd12;
    localparam logic [CLS_W-1:0] C_KH    = 5'd13;
    localparam logic [CLS_W-1:0] C_HKH   = 5'd14;
    localparam logic [CLS_W-1:0] C_MISC  = 5'd16;
    localparam logic [CLS_W-1:0] C_KOH   = 5'd17;

    localparam logic [CIDX_W-1:0] REG_LIMITS_LOW = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LIMITS_MID = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LIMIT_MISC = 2'd2;

    localparam logic [CFG_W-1:0] LIMITS_RESET = 64'd1157442765409226768;
    localparam logic [LIM_W-1:0] MISC_RESET   = 8'd16;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             change;
        logic             kill;
    } t_merge;

endpackage

// ===== sv/ssc_hist.sv =====
// class history memory, one write and one registered read port
module ssc_hist #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ssc_pkg::CLS_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [ssc_pkg::CLS_W-1:0] o_rdata
);

    logic [ssc_pkg::CLS_W-1:0] r_mem [DEPTH];
    logic [ssc_pkg::CLS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ssc_merge.sv =====
// merge of the running class with one earlier class
module ssc_merge (
    input  logic [ssc_pkg::CLS_W-1:0] i_run,
    input  logic [ssc_pkg::CLS_W-1:0] i_prev,
    input  logic                      i_changed,
    output ssc_pkg::t_merge           o_res
);

    logic                      w_diff;
    logic [ssc_pkg::CLS_W-1:0] w_cls;

    assign w_diff = (i_run != i_prev);

    always_comb begin
        w_cls = i_run;
        case (i_prev)
            ssc_pkg::C_HIRA: begin
                case (i_run)
                    ssc_pkg::C_KATA:  w_cls = ssc_pkg::C_HK;
                    ssc_pkg::C_HANJI: w_cls = ssc_pkg::C_HH;
                    ssc_pkg::C_KH:    w_cls = ssc_pkg::C_HKH;
                    ssc_pkg::C_KOH:   w_cls = ssc_pkg::C_HIRA;
                    default: begin
                        if (!(i_run inside {ssc_pkg::C_HH, ssc_pkg::C_HK, ssc_pkg::C_HKH,
                                            ssc_pkg::C_HIRA})) begin
                            w_cls = ssc_pkg::C_MISC;
                        end
                    end
                endcase
            end
            ssc_pkg::C_KATA: begin
                case (i_run)
                    ssc_pkg::C_HIRA:  w_cls = ssc_pkg::C_HK;
                    ssc_pkg::C_HANJI: w_cls = ssc_pkg::C_KH;
                    ssc_pkg::C_HH:    w_cls = ssc_pkg::C_HKH;
                    ssc_pkg::C_KOH:   w_cls = ssc_pkg::C_KATA;
                    default: begin
                        if (!(i_run inside {ssc_pkg::C_HK, ssc_pkg::C_KH, ssc_pkg::C_HKH,
                                            ssc_pkg::C_KATA})) begin
                            w_cls = ssc_pkg::C_MISC;
                        end
                    end
                endcase
            end
            ssc_pkg::C_HANJI: begin
                case (i_run)
                    ssc_pkg::C_HIRA: w_cls = ssc_pkg::C_HH;
                    ssc_pkg::C_KATA: w_cls = ssc_pkg::C_KH;
                    ssc_pkg::C_HK:   w_cls = ssc_pkg::C_HKH;
                    ssc_pkg::C_KOH:  w_cls = ssc_pkg::C_HKH;
                    default: begin
                        if (!(i_run inside {ssc_pkg::C_HH, ssc_pkg::C_KH, ssc_pkg::C_HKH,
                                            ssc_pkg::C_HANJI})) begin
                            w_cls = ssc_pkg::C_MISC;
                        end
                    end
                endcase
            end
            ssc_pkg::C_KOH: begin
                // any running class ends up as misc here
                w_cls = ssc_pkg::C_MISC;
            end
            default: begin
                if (w_diff) begin
                    w_cls = ssc_pkg::C_MISC;
                end
            end
        endcase
    end

    assign o_res.cls    = w_cls;
    assign o_res.change = i_changed | w_diff;
    assign o_res.kill   = i_changed & w_diff;

endmodule

// ===== sv/script_run_segment_candidates.sv =====
// top level: history, walk sequencer and span limit registers
// Usage:
//   input channel  : i_valid / o_ready, word = i_char_class, i_sentence_start
//   output channel : o_valid / i_ready, word = o_candidate_count
//   config port    : i_cfg_we, i_cfg_idx, i_cfg_data; to be written only while
//                    no word is in flight; the block itself does not enforce this
// One word is worked at a time. The accept cycle stores the class in the
// history memory, then the walk visits the classes from newest to older, each
// visit one merge in the merge unit and one limit compare, from 1 up to MAX_SEG
// classes; the history memory read port fetches the next older class each
// cycle. The count then sits in the output register until taken.
// A stalled receiver holds the result and o_ready stays low until it is taken.
// Reset empties the history (fill count zero), restores the default limits
// and returns the block to idle; the history memory itself is not cleared.
module script_run_segment_candidates #(
    parameter int MAX_SEG = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ssc_pkg::CLS_W-1:0]  i_char_class,
    input  logic                       i_sentence_start,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ssc_pkg::CNT_W-1:0]  o_candidate_count,
    input  logic                       i_cfg_we,
    input  logic [ssc_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [ssc_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_SEG > 1) ? $clog2(MAX_SEG) : 1;
    localparam int CW = $clog2(MAX_SEG + 1);
    localparam int DW = CW + 1;
    localparam int LW = (CW > ssc_pkg::LIM_W) ? CW : ssc_pkg::LIM_W;
    localparam logic [CW-1:0] FULL     = CW'(MAX_SEG);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_SEG - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [ssc_pkg::CLS_W-1:0] r_cls, n_cls;
    logic [ssc_pkg::CLS_W-1:0] r_run, n_run;
    logic r_changed, n_changed;
    logic [ssc_pkg::CFG_W-1:0] r_lim_low, r_lim_mid;
    logic [ssc_pkg::LIM_W-1:0] r_lim_misc;

    logic                      w_accept;
    logic [CW-1:0]             w_base;
    logic [CW-1:0]             w_next_idx;
    logic [DW-1:0]             w_radr_sum;
    logic [AW-1:0]             w_raddr;
    logic [ssc_pkg::CLS_W-1:0] w_rdata;
    logic [ssc_pkg::CLS_W-1:0] w_prev;
    ssc_pkg::t_merge           w_merge;
    logic [ssc_pkg::LIM_W-1:0] w_lim;
    logic                      w_stop;

    assign w_accept   = i_valid & o_ready;
    assign w_next_idx = r_idx + CW'(1);

    // entry k lives at head - k, modulo the depth
    always_comb begin
        w_radr_sum = DW'(r_head) + DW'(MAX_SEG) - DW'(w_next_idx);
        if (w_radr_sum >= DW'(MAX_SEG)) begin
            w_radr_sum = w_radr_sum - DW'(MAX_SEG);
        end
    end
    assign w_raddr = w_radr_sum[AW-1:0];

    ssc_hist #(
        .DEPTH(MAX_SEG),
        .AW   (AW)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_accept),
        .i_waddr(n_head),
        .i_wdata(i_char_class),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_prev = (r_idx == '0) ? r_cls : w_rdata;

    ssc_merge u_merge (
        .i_run    (r_run),
        .i_prev   (w_prev),
        .i_changed(r_changed),
        .o_res    (w_merge)
    );

    always_comb begin
        if (w_merge.cls < 5'd8) begin
            w_lim = r_lim_low[w_merge.cls[2:0]*8 +: 8];
        end else if (w_merge.cls < 5'd16) begin
            w_lim = r_lim_mid[w_merge.cls[2:0]*8 +: 8];
        end else begin
            w_lim = r_lim_misc;
        end
    end

    // the index never reaches MAX_SEG, so clamping the limit to MAX_SEG would change nothing
    assign w_stop = w_merge.kill | (LW'(r_idx) >= LW'(w_lim));

    assign w_base = i_sentence_start ? '0 : r_fill;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_count   = r_count;
        n_head    = r_head;
        n_cls     = r_cls;
        n_run     = r_run;
        n_changed = r_changed;
        if (w_accept) begin
            n_head    = (r_head == LAST_ADR) ? '0 : r_head + AW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_fill    = (w_base == FULL) ? w_base : w_base + CW'(1);
                    n_cls     = i_char_class;
                    n_run     = i_char_class;
                    n_changed = 1'b0;
                    n_idx     = '0;
                    n_count   = '0;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if (w_stop) begin
                    n_state = S_OUT;
                end else begin
                    n_count   = r_count + CW'(1);
                    n_idx     = w_next_idx;
                    n_run     = w_merge.cls;
                    n_changed = w_merge.change;
                    if (w_next_idx == r_fill) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_head     <= '0;
            r_lim_low  <= ssc_pkg::LIMITS_RESET;
            r_lim_mid  <= ssc_pkg::LIMITS_RESET;
            r_lim_misc <= ssc_pkg::MISC_RESET;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_head  <= n_head;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssc_pkg::REG_LIMITS_LOW: r_lim_low  <= i_cfg_data;
                    ssc_pkg::REG_LIMITS_MID: r_lim_mid  <= i_cfg_data;
                    ssc_pkg::REG_LIMIT_MISC: r_lim_misc <= i_cfg_data[ssc_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        r_idx     <= n_idx;
        r_count   <= n_count;
        r_cls     <= n_cls;
        r_run     <= n_run;
        r_changed <= n_changed;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_candidate_count = ssc_pkg::CNT_W'(r_count);

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("history fill beyond depth");

    a_walk_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx < r_fill))
        else $error("walk index past history fill");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count <= r_fill))
        else $error("count exceeds history fill");

    a_fill_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_fill != '0) && (r_state == S_WALK))
        else $error("accepted word did not start a walk");

    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (o_ready && !o_valid))
        else $error("block not idle after result taken");

endmodule

// ===== tb/sv/candidate_count_checker.sv =====
// checker: tracks class history and span limits, predicts and compares candidate counts
module candidate_count_checker #(
    parameter int MAX_SEG = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [ssc_pkg::CLS_W-1:0]  i_char_class,
    input  logic                       i_sentence_start,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [ssc_pkg::CNT_W-1:0]  i_candidate_count,
    input  logic                       i_cfg_we,
    input  logic [ssc_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [ssc_pkg::CFG_W-1:0]  i_cfg_data,
    output int unsigned                o_fail_count,
    output int unsigned                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ssc_pkg::CFG_W-1:0] lim_low;
    logic [ssc_pkg::CFG_W-1:0] lim_mid;
    logic [ssc_pkg::LIM_W-1:0] lim_misc;
    logic [ssc_pkg::CLS_W-1:0] hist [MAX_SEG];
    int unsigned               fill;
    int unsigned               mismatches;
    logic [ssc_pkg::CNT_W-1:0] expected_counts [$];

    function automatic int unsigned span_of(input logic [ssc_pkg::CLS_W-1:0] c);
        logic [ssc_pkg::LIM_W-1:0] b;
        if (c < 8)
            b = lim_low[8*c +: 8];
        else if (c < 16)
            b = lim_mid[8*(c-8) +: 8];
        else
            b = lim_misc;
        return (b > MAX_SEG) ? MAX_SEG : b;
    endfunction

    function automatic int unsigned merge_class(inout logic [ssc_pkg::CLS_W-1:0] t,
                                                input logic [ssc_pkg::CLS_W-1:0] u,
                                                inout int unsigned changes);
        logic [ssc_pkg::CLS_W-1:0] c;
        c = t;
        if (c != u)
            changes++;
        if (changes > 1)
            return 0;
        case (u)
            ssc_pkg::C_HIRA: begin
                if (c == ssc_pkg::C_KATA) c = ssc_pkg::C_HK;
                else if (c == ssc_pkg::C_HANJI) c = ssc_pkg::C_HH;
                else if (c == ssc_pkg::C_KH) c = ssc_pkg::C_HKH;
                else if (c == ssc_pkg::C_KOH) c = ssc_pkg::C_HIRA;
                else if (c != ssc_pkg::C_HH && c != ssc_pkg::C_HK &&
                         c != ssc_pkg::C_HKH && c != u)
                    c = ssc_pkg::C_MISC;
            end
            ssc_pkg::C_KATA: begin
                if (c == ssc_pkg::C_HIRA) c = ssc_pkg::C_HK;
                else if (c == ssc_pkg::C_HANJI) c = ssc_pkg::C_KH;
                else if (c == ssc_pkg::C_HH) c = ssc_pkg::C_HKH;
                else if (c == ssc_pkg::C_KOH) c = ssc_pkg::C_KATA;
                else if (c != ssc_pkg::C_HK && c != ssc_pkg::C_KH &&
                         c != ssc_pkg::C_HKH && c != u)
                    c = ssc_pkg::C_MISC;
            end
            ssc_pkg::C_HANJI: begin
                if (c == ssc_pkg::C_HIRA) c = ssc_pkg::C_HH;
                else if (c == ssc_pkg::C_KATA) c = ssc_pkg::C_KH;
                else if (c == ssc_pkg::C_HK) c = ssc_pkg::C_HKH;
                else if (c == ssc_pkg::C_KOH) c = ssc_pkg::C_HKH;
                else if (c != ssc_pkg::C_HH && c != ssc_pkg::C_KH &&
                         c != ssc_pkg::C_HKH && c != u)
                    c = ssc_pkg::C_MISC;
            end
            default: begin
                // kata_or_hira as the visited class falls through to the mismatch rule
                if (u == ssc_pkg::C_KOH && c != ssc_pkg::C_HIRA && c != ssc_pkg::C_KATA &&
                    c != ssc_pkg::C_HK && c != ssc_pkg::C_KH && c != ssc_pkg::C_HH &&
                    c != ssc_pkg::C_HKH)
                    c = ssc_pkg::C_MISC;
                if (c != u)
                    c = ssc_pkg::C_MISC;
            end
        endcase
        t = c;
        return span_of(c);
    endfunction

    function automatic logic [ssc_pkg::CNT_W-1:0] count_candidates();
        logic [ssc_pkg::CLS_W-1:0] run;
        int unsigned               changes;
        int unsigned               n;
        int unsigned               lim;
        run = hist[0];
        changes = 0;
        n = 0;
        for (int i = 0; i < fill; i++) begin
            lim = merge_class(run, hist[i], changes);
            if (i >= lim)
                break;
            n++;
        end
        return ssc_pkg::CNT_W'(n);
    endfunction

    always @(posedge i_clk) begin
        logic [ssc_pkg::CNT_W-1:0] want;
        if (!i_rst_n) begin
            lim_low = ssc_pkg::LIMITS_RESET;
            lim_mid = ssc_pkg::LIMITS_RESET;
            lim_misc = ssc_pkg::MISC_RESET;
            fill = 0;
            mismatches = 0;
            expected_counts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssc_pkg::REG_LIMITS_LOW: lim_low = i_cfg_data;
                    ssc_pkg::REG_LIMITS_MID: lim_mid = i_cfg_data;
                    ssc_pkg::REG_LIMIT_MISC: lim_misc = i_cfg_data[ssc_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, candidate_count %0d", $time,
                             i_candidate_count);
                end else begin
                    want = expected_counts.pop_front();
                    if (want !== i_candidate_count) begin
                        mismatches++;
                        $display("%0t: candidate_count expected %0d, got %0d", $time,
                                 want, i_candidate_count);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_sentence_start)
                    fill = 0;
                for (int i = MAX_SEG - 1; i > 0; i--)
                    hist[i] = hist[i-1];
                hist[0] = i_char_class;
                if (fill < MAX_SEG)
                    fill++;
                want = count_candidates();
                expected_counts = {expected_counts, want};
            end
        end
        o_fail_count <= mismatches;
        o_outstanding <= expected_counts.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: clock, reset, stimulus, receiver and verdict for the segment candidate counter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_SEG   = 16;
    localparam int unsigned RUN_LIMIT = 400000;
    localparam int unsigned PHASE_LEN = 171;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [ssc_pkg::CLS_W-1:0]  i_char_class = '0;
    logic                       i_sentence_start = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [ssc_pkg::CNT_W-1:0]  o_candidate_count;
    logic                       i_cfg_we = 1'b0;
    logic [ssc_pkg::CIDX_W-1:0] i_cfg_idx = ssc_pkg::REG_LIMITS_LOW;
    logic [ssc_pkg::CFG_W-1:0]  i_cfg_data = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned sent = 0;
    int unsigned cycle_count = 0;

    script_run_segment_candidates #(.MAX_SEG(MAX_SEG)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_class     (i_char_class),
        .i_sentence_start (i_sentence_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_candidate_count(o_candidate_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    candidate_count_checker #(.MAX_SEG(MAX_SEG)) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_char_class     (i_char_class),
        .i_sentence_start (i_sentence_start),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_candidate_count(o_candidate_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!i_rst_n)
                i_ready <= 1'b0;
            else if (cyc >= 3000 && cyc < 3500)
                i_ready <= 1'b0;
            else if (cyc >= 8000 && cyc < 12000)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 99) >= 14);
        end
    end

    task automatic offer_word(input logic [ssc_pkg::CLS_W-1:0] cls, input logic start);
        if (!(sent >= 500 && sent < 750)) begin
            while ($urandom_range(0, 99) < 14) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_char_class <= cls;
        i_sentence_start <= start;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic load_limits(input logic [ssc_pkg::CFG_W-1:0] lo,
                               input logic [ssc_pkg::CFG_W-1:0] mid,
                               input logic [ssc_pkg::LIM_W-1:0] misc);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ssc_pkg::REG_LIMITS_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx <= ssc_pkg::REG_LIMITS_MID;
        i_cfg_data <= mid;
        @(posedge i_clk);
        // upper bits carry junk, only the low byte counts
        i_cfg_idx <= ssc_pkg::REG_LIMIT_MISC;
        i_cfg_data <= {24'($urandom), $urandom, misc};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ssc_pkg::CFG_W-1:0] limit_bytes(input int unsigned lo_b,
                                                              input int unsigned hi_b);
        logic [ssc_pkg::CFG_W-1:0] v;
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = 8'($urandom_range(lo_b, hi_b));
        return v;
    endfunction

    function automatic logic [ssc_pkg::CLS_W-1:0] pick_class(
        input logic [ssc_pkg::CLS_W-1:0] prev,
        input int unsigned stick
    );
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < stick)
            return prev;
        r = $urandom_range(0, 99);
        if (r < 60)
            return ssc_pkg::C_HIRA +
                   ssc_pkg::CLS_W'($urandom_range(0, ssc_pkg::C_HKH - ssc_pkg::C_HIRA));
        else if (r < 72)
            return ssc_pkg::C_KOH;
        else if (r < 90)
            return ssc_pkg::CLS_W'($urandom_range(0, ssc_pkg::C_KOH));
        else
            return ssc_pkg::CLS_W'($urandom_range(0, (1 << ssc_pkg::CLS_W) - 1));
    endfunction

    // sentences with random content, some with stray sentence starts
    task automatic random_sentences(input int unsigned n);
        int unsigned               done_n;
        int unsigned               len;
        int unsigned               stick;
        logic                      noisy;
        logic [ssc_pkg::CLS_W-1:0] cls;
        done_n = 0;
        cls = ssc_pkg::C_HIRA;
        while (done_n < n) begin
            len = $urandom_range(1, 40);
            stick = $urandom_range(0, 1) ? 92 : 40;
            noisy = ($urandom_range(0, 9) == 0);
            cls = pick_class(cls, 0);
            for (int k = 0; k < len && done_n < n; k++) begin
                if (k != 0)
                    cls = pick_class(cls, stick);
                offer_word(cls, noisy ? 1'($urandom_range(0, 1)) : (k == 0));
                done_n++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // classes 0 to C_KOH + 1 and the all-ones class in one sentence, past a full history
        offer_word('0, 1'b1);
        for (int c = 1; c <= ssc_pkg::C_KOH; c++)
            offer_word(ssc_pkg::CLS_W'(c), 1'b0);
        offer_word('1, 1'b0);
        offer_word(ssc_pkg::CLS_W'(ssc_pkg::C_KOH + 1), 1'b0);
        offer_word(ssc_pkg::C_HIRA, 1'b1);
        offer_word(ssc_pkg::C_HIRA, 1'b0);
        offer_word(ssc_pkg::C_KATA, 1'b0);
        offer_word(ssc_pkg::C_HANJI, 1'b0);
        offer_word(ssc_pkg::C_KOH, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_limits('1, '1, '1);
                1: load_limits('0, '0, '0);
                2: load_limits(limit_bytes(0, 18), limit_bytes(0, 18),
                               8'($urandom_range(0, 18)));
                3: load_limits({$urandom, $urandom}, {$urandom, $urandom},
                               8'($urandom));
                4: load_limits(limit_bytes(1, 17), limit_bytes(1, 17),
                               8'($urandom_range(1, 17)));
                default: load_limits(ssc_pkg::LIMITS_RESET, ssc_pkg::LIMITS_RESET,
                                     ssc_pkg::MISC_RESET);
            endcase
            random_sentences(PHASE_LEN);
            drain();
        end

        repeat (MAX_SEG + 8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
